@@ rtl/nnir_pkg.sv @@
// ----------------------------------------------------------------------------
// nnir_pkg
// Shared types, widths and constants for the nearest-neighbor image rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package nnir_pkg;

    // Default frame store side; the top level hands this down as MAX_DIM.
    localparam int MAX_DIM_DEF = 256;

    // Field widths fixed by the item formats.
    localparam int ROW_W   = 9;
    localparam int PIX_W   = 24;
    localparam int SRC_W   = 9;
    localparam int OSZ_W   = 10;
    localparam int TRIG_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Fixed-point arithmetic: Q1.14 angles, centered coordinates and sums.
    localparam int Q_FRAC   = 14;
    localparam int Q_HALF   = 1 << (Q_FRAC - 1);
    localparam int RND_BIAS = (1 << Q_FRAC) - 1;
    localparam int DI_W     = ROW_W + 1;
    localparam int P_W      = DI_W + TRIG_W;
    localparam int T_W      = P_W + 1;
    localparam int R_W      = T_W - Q_FRAC;
    localparam int X_W      = R_W + 1;

    // Register reset values.
    localparam int RST_SOURCE_ROWS = 256;
    localparam int RST_SOURCE_COLS = 256;
    localparam int RST_OUTPUT_SIZE = 363;
    localparam int RST_COS_ANGLE   = 16384;
    localparam int RST_SIN_ANGLE   = 0;

    // Item kinds.
    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_REQUEST = 1'b1
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_ROWS = 3'd0,
        REG_SOURCE_COLS = 3'd1,
        REG_OUTPUT_SIZE = 3'd2,
        REG_COS_ANGLE   = 3'd3,
        REG_SIN_ANGLE   = 3'd4
    } cfg_reg_t;

    // Input item.
    typedef struct packed {
        kind_t             kind;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [PIX_W-1:0]  pixel_in;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [PIX_W-1:0]  pixel_out;
        logic              inside_res;
    } out_item_t;

    // Configuration as seen by the datapath, with derived halves and limits.
    typedef struct packed {
        logic [SRC_W-1:0]         half_out;
        logic [SRC_W-2:0]         half_rows;
        logic [SRC_W-2:0]         half_cols;
        logic [SRC_W-1:0]         lim_rows;
        logic [SRC_W-1:0]         lim_cols;
        logic signed [TRIG_W-1:0] cos_angle;
        logic signed [TRIG_W-1:0] sin_angle;
    } cfg_t;

    // Item leaving the coordinate pipeline: original item plus rounded offsets.
    typedef struct packed {
        in_item_t              item;
        logic signed [R_W-1:0] rx;
        logic signed [R_W-1:0] ry;
    } map_item_t;

endpackage

`default_nettype wire

@@ rtl/nnir_cfg.sv @@
// ----------------------------------------------------------------------------
// nnir_cfg
// Configuration register file; also derives the halves and clamped limits.
// ----------------------------------------------------------------------------
`default_nettype none

module nnir_cfg #(
    parameter int MAX_DIM = nnir_pkg::MAX_DIM_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    input  wire [nnir_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [nnir_pkg::CFG_DATA_W-1:0]   cfg_data,
    output nnir_pkg::cfg_t                   cfg
);
    import nnir_pkg::*;

    localparam logic [SRC_W-1:0] LIM_RST_ROWS = (RST_SOURCE_ROWS < MAX_DIM) ?
        SRC_W'(RST_SOURCE_ROWS) : SRC_W'(MAX_DIM);
    localparam logic [SRC_W-1:0] LIM_RST_COLS = (RST_SOURCE_COLS < MAX_DIM) ?
        SRC_W'(RST_SOURCE_COLS) : SRC_W'(MAX_DIM);

    logic [SRC_W-1:0]         rows_reg;
    logic [SRC_W-1:0]         cols_reg;
    logic [SRC_W-1:0]         lim_rows_reg;
    logic [SRC_W-1:0]         lim_cols_reg;
    logic [OSZ_W-1:0]         out_size_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic [SRC_W-1:0]         lim_next;

    // A source size at or above the frame store side clamps to that side.
    always_comb begin
        if (int'(cfg_data[SRC_W-1:0]) < MAX_DIM) begin
            lim_next = cfg_data[SRC_W-1:0];
        end else begin
            lim_next = SRC_W'(MAX_DIM);
        end
    end

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg     <= SRC_W'(RST_SOURCE_ROWS);
            cols_reg     <= SRC_W'(RST_SOURCE_COLS);
            lim_rows_reg <= LIM_RST_ROWS;
            lim_cols_reg <= LIM_RST_COLS;
            out_size_reg <= OSZ_W'(RST_OUTPUT_SIZE);
            cos_reg      <= TRIG_W'(RST_COS_ANGLE);
            sin_reg      <= TRIG_W'(RST_SIN_ANGLE);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SOURCE_ROWS: begin
                    rows_reg     <= cfg_data[SRC_W-1:0];
                    lim_rows_reg <= lim_next;
                end
                REG_SOURCE_COLS: begin
                    cols_reg     <= cfg_data[SRC_W-1:0];
                    lim_cols_reg <= lim_next;
                end
                REG_OUTPUT_SIZE: out_size_reg <= cfg_data[OSZ_W-1:0];
                REG_COS_ANGLE:   cos_reg      <= $signed(cfg_data[TRIG_W-1:0]);
                REG_SIN_ANGLE:   sin_reg      <= $signed(cfg_data[TRIG_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Integer halves are plain right shifts.
    assign cfg.half_out  = out_size_reg[OSZ_W-1:1];
    assign cfg.half_rows = rows_reg[SRC_W-1:1];
    assign cfg.half_cols = cols_reg[SRC_W-1:1];
    assign cfg.lim_rows  = lim_rows_reg;
    assign cfg.lim_cols  = lim_cols_reg;
    assign cfg.cos_angle = cos_reg;
    assign cfg.sin_angle = sin_reg;

endmodule

`default_nettype wire

@@ rtl/nnir_map.sv @@
// ----------------------------------------------------------------------------
// nnir_map
// Four-stage coordinate pipeline: center, multiply, sum, round.
// ----------------------------------------------------------------------------
`default_nettype none

module nnir_map (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  nnir_pkg::cfg_t         cfg,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  nnir_pkg::in_item_t     s_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output nnir_pkg::map_item_t    out_data
);
    import nnir_pkg::*;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic                  rdy1, rdy2, rdy3, rdy4;
    in_item_t              item1_reg, item2_reg, item3_reg;
    logic signed [DI_W-1:0] di1_reg, dj1_reg, di1_next, dj1_next;
    logic signed [P_W-1:0] pdc2_reg, pds2_reg, pis2_reg, pjc2_reg;
    logic signed [P_W-1:0] pdc2_next, pds2_next, pis2_next, pjc2_next;
    logic signed [T_W-1:0] tx3_reg, ty3_reg, tx3_next, ty3_next;
    logic signed [T_W-1:0] bias_x, bias_y, rnd_x, rnd_y;
    map_item_t             out_reg, out_next;

    // A stage takes a new item when it is empty or its item moves on.
    assign rdy4    = !v4_reg || out_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // Stage 1: center the output coordinates on half the output size.
    assign di1_next = $signed({1'b0, s_data.row}) - $signed({1'b0, cfg.half_out});
    assign dj1_next = $signed({1'b0, s_data.col}) - $signed({1'b0, cfg.half_out});

    // Stage 2: the four rotation products.
    assign pdc2_next = P_W'(di1_reg) * P_W'(cfg.cos_angle);
    assign pds2_next = P_W'(dj1_reg) * P_W'(cfg.sin_angle);
    assign pis2_next = P_W'(di1_reg) * P_W'(cfg.sin_angle);
    assign pjc2_next = P_W'(dj1_reg) * P_W'(cfg.cos_angle);

    // Stage 3: rotated Q14 coordinates plus one half.
    assign tx3_next = T_W'(pdc2_reg) - T_W'(pds2_reg) + T_W'(Q_HALF);
    assign ty3_next = T_W'(pis2_reg) + T_W'(pjc2_reg) + T_W'(Q_HALF);

    // Stage 4: truncate toward zero; negative values get a bias before the shift.
    always_comb begin
        bias_x = tx3_reg[T_W-1] ? T_W'(RND_BIAS) : T_W'(0);
        bias_y = ty3_reg[T_W-1] ? T_W'(RND_BIAS) : T_W'(0);
        rnd_x  = tx3_reg + bias_x;
        rnd_y  = ty3_reg + bias_y;
        out_next.item = item3_reg;
        out_next.rx   = R_W'(rnd_x >>> Q_FRAC);
        out_next.ry   = R_W'(rnd_y >>> Q_FRAC);
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Stage payload registers.
    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            item1_reg <= s_data;
            di1_reg   <= di1_next;
            dj1_reg   <= dj1_next;
        end
        if (rdy2 && v1_reg) begin
            item2_reg <= item1_reg;
            pdc2_reg  <= pdc2_next;
            pds2_reg  <= pds2_next;
            pis2_reg  <= pis2_next;
            pjc2_reg  <= pjc2_next;
        end
        if (rdy3 && v2_reg) begin
            item3_reg <= item2_reg;
            tx3_reg   <= tx3_next;
            ty3_reg   <= ty3_next;
        end
        if (rdy4 && v3_reg) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

    // A stalled last stage keeps its item.
    a_hold_last: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !out_ready |=> v4_reg && $stable(out_reg))
        else $error("nnir_map: last stage changed while stalled");

    // A stalled first stage keeps its centered coordinates.
    a_hold_first: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !rdy2 |=> v1_reg && $stable(di1_reg) && $stable(dj1_reg))
        else $error("nnir_map: first stage changed while stalled");

    // An item in stage 3 that may move is found in stage 4 next cycle.
    a_move_on: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && rdy4 |=> v4_reg)
        else $error("nnir_map: item lost between stages 3 and 4");

endmodule

`default_nettype wire

@@ rtl/nnir_fetch.sv @@
// ----------------------------------------------------------------------------
// nnir_fetch
// Bounds check, frame store access and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nnir_fetch #(
    parameter int MAX_DIM = nnir_pkg::MAX_DIM_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  nnir_pkg::cfg_t         cfg,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  nnir_pkg::map_item_t    in_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output nnir_pkg::out_item_t    m_data
);
    import nnir_pkg::*;

    localparam int DW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * DW;
    localparam int DEPTH = 1 << AW;

    logic [PIX_W-1:0]   mem [DEPTH];

    logic               v5_reg, v6_reg;
    logic               rdy5, rdy6;
    kind_t              kind5_reg;
    logic               hit5_reg, hit5_next;
    logic [AW-1:0]      addr5_reg, addr5_next;
    logic [PIX_W-1:0]   pix5_reg;
    logic               inside6_reg;
    logic [PIX_W-1:0]   rd_reg;
    logic signed [X_W-1:0] xs, ys;
    logic               in_x, in_y;

    // Loads leave at the write stage, so only requests need the result slot.
    assign rdy6     = !v6_reg || m_ready;
    assign rdy5     = !v5_reg || (kind5_reg == KIND_LOAD) || rdy6;
    assign in_ready = rdy5;

    // Re-center on half the source size and test against the clamped limits; loads check the store side.
    always_comb begin
        xs   = X_W'(in_data.rx) + X_W'($signed({1'b0, cfg.half_rows}));
        ys   = X_W'(in_data.ry) + X_W'($signed({1'b0, cfg.half_cols}));
        in_x = !xs[X_W-1] && (xs[X_W-2:0] < (X_W-1)'(cfg.lim_rows));
        in_y = !ys[X_W-1] && (ys[X_W-2:0] < (X_W-1)'(cfg.lim_cols));
        if (in_data.item.kind == KIND_LOAD) begin
            hit5_next  = (int'(in_data.item.row) < MAX_DIM) &&
                         (int'(in_data.item.col) < MAX_DIM);
            addr5_next = {DW'(in_data.item.row), DW'(in_data.item.col)};
        end else begin
            hit5_next  = in_x && in_y;
            addr5_next = {DW'(xs), DW'(ys)};
        end
    end

    // Control state of both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy5) v5_reg <= in_valid;
            if (rdy6) v6_reg <= v5_reg && (kind5_reg == KIND_REQUEST);
        end
    end

    // Stage 5 payload.
    always_ff @(posedge aclk) begin
        if (rdy5 && in_valid) begin
            kind5_reg <= in_data.item.kind;
            hit5_reg  <= hit5_next;
            addr5_reg <= addr5_next;
            pix5_reg  <= in_data.item.pixel_in;
        end
    end

    // Frame store: one access a cycle, loads write and requests read in order.
    always_ff @(posedge aclk) begin
        if (v5_reg && (kind5_reg == KIND_LOAD) && hit5_reg) begin
            mem[addr5_reg] <= pix5_reg;
        end else if (rdy6 && v5_reg && (kind5_reg == KIND_REQUEST) && hit5_reg) begin
            rd_reg <= mem[addr5_reg];
        end
    end

    // Result flag follows the read.
    always_ff @(posedge aclk) begin
        if (rdy6 && v5_reg && (kind5_reg == KIND_REQUEST)) begin
            inside6_reg <= hit5_reg;
        end
    end

    assign m_valid           = v6_reg;
    assign m_data.inside_res = inside6_reg;
    assign m_data.pixel_out  = inside6_reg ? rd_reg : '0;

    // A result only ever comes from a request.
    a_req_only: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v6_reg) |-> $past(v5_reg && (kind5_reg == KIND_REQUEST)))
        else $error("nnir_fetch: result appeared without a request");

    // A waiting result keeps its data.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        v6_reg && !m_ready |=> v6_reg && $stable(rd_reg) && $stable(inside6_reg))
        else $error("nnir_fetch: waiting result changed");

    // A load at the write stage never stalls.
    a_load_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg && (kind5_reg == KIND_LOAD) |-> in_ready)
        else $error("nnir_fetch: load stalled at the write stage");

endmodule

`default_nettype wire

@@ rtl/nearest_neighbour_image_rotate.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbour_image_rotate
// Rotates an RGB frame by inverse mapping with nearest-neighbor sampling.
//
// Input channel (s_valid/s_ready/s_data) carries load items, which write one
// source pixel into the frame store, and request items, which ask for one
// output pixel. Each request yields one result item on the m_ channel; loads
// yield none. Configuration writes come on cfg_valid/cfg_ready/cfg_index/
// cfg_data, are always accepted, and must only happen while no item is in
// flight. One item can enter per cycle while no stage stalls; a result
// leaves once its request has passed the center, multiply, sum, round,
// bounds check and frame store read stages. The single-port frame store
// sets the rate: one access per item. Reset clears the pipeline valid bits
// and sets the registers to their defaults; the frame store is not cleared
// and must be loaded before use. When the receiver stalls, items back up
// stage by stage and s_ready drops only once every stage holds an item;
// loads keep draining past the frame store even while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbour_image_rotate #(
    parameter int MAX_DIM = nnir_pkg::MAX_DIM_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  nnir_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  wire                             m_ready,
    output nnir_pkg::out_item_t             m_data,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [nnir_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [nnir_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import nnir_pkg::*;

    cfg_t      cfg;
    logic      map_valid;
    logic      map_ready;
    map_item_t map_data;

    // Register writes are taken every cycle.
    assign cfg_ready = 1'b1;

    nnir_cfg #(
        .MAX_DIM   (MAX_DIM)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nnir_map u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_valid (map_valid),
        .out_ready (map_ready),
        .out_data  (map_data)
    );

    nnir_fetch #(
        .MAX_DIM   (MAX_DIM)
    ) u_fetch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (map_valid),
        .in_ready  (map_ready),
        .in_data   (map_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the nearest-neighbor image rotator.
//
// Items go in on the s_ channel and results come out on the m_ channel; both
// use valid/ready. A predictor in this file keeps its own copy of the frame
// store and of the five registers. It works out, for each accepted request,
// which source pixel the block should return and whether that position lies
// inside the source frame. Each result is compared field by field with the
// oldest pending prediction.
//
// Directed tests cover the frame corners, loads that fall outside the store,
// zero and oversized source sizes, and out-of-range cosine and sine codes.
// Random phases then vary the registers and the idle mix on both channels. A
// last test holds the output off long enough for the block to stall its
// input. A request never reads a store entry that has not been loaded: when a
// request would map onto one, a load for that entry is sent first.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nnir_pkg::*;

    localparam int FRAME_DIM       = MAX_DIM_DEF;
    localparam int DRAIN_CYCLES    = 12;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 72;
    localparam int MAX_PRINTED     = 40;
    localparam int ROW_MAX         = (1 << ROW_W) - 1;

    // Clock, reset and block ports; every input starts at a known value.
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: frame store contents and the register copies.
    logic [PIX_W-1:0]         frame_image  [FRAME_DIM*FRAME_DIM];
    bit                       frame_loaded [FRAME_DIM*FRAME_DIM];
    logic [SRC_W-1:0]         src_rows = SRC_W'(RST_SOURCE_ROWS);
    logic [SRC_W-1:0]         src_cols = SRC_W'(RST_SOURCE_COLS);
    logic [OSZ_W-1:0]         out_side = OSZ_W'(RST_OUTPUT_SIZE);
    logic signed [TRIG_W-1:0] cos_q14  = TRIG_W'(RST_COS_ANGLE);
    logic signed [TRIG_W-1:0] sin_q14  = TRIG_W'(RST_SIN_ANGLE);

    // Predicted results, oldest first.
    out_item_t expected_pixels[$];

    int   error_count   = 0;
    int   load_count    = 0;
    int   request_count = 0;
    int   result_count  = 0;
    int   write_count   = 0;
    int   setting_count = 0;
    int   cycle_count   = 0;
    int   src_idle_pct  = 0;
    int   dst_stall_pct = 0;
    logic output_hold   = 1'b0;

    nearest_neighbour_image_rotate #(
        .MAX_DIM(FRAME_DIM)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Overall time limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still pending.",
                     cycle_count, expected_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
        error_count++;
    endtask

    // Add one half pixel, then truncate toward zero by the fraction bits.
    function automatic longint round_to_pixel(input longint v);
        longint t;
        t = v + Q_HALF;
        if (t >= 0) begin
            return t >>> Q_FRAC;
        end
        return -((-t) >>> Q_FRAC);
    endfunction

    // Map an output position back into the source frame.
    function automatic void map_to_source(input logic [ROW_W-1:0] orow,
                                          input logic [ROW_W-1:0] ocol,
                                          output int xs, output int ys,
                                          output bit hit);
        longint half_out, di, dj, x, y, lim_r, lim_c;
        half_out = longint'(out_side >> 1);
        di = longint'(orow) - half_out;
        dj = longint'(ocol) - half_out;
        x = round_to_pixel(di * longint'(cos_q14) - dj * longint'(sin_q14))
            + longint'(src_rows >> 1);
        y = round_to_pixel(di * longint'(sin_q14) + dj * longint'(cos_q14))
            + longint'(src_cols >> 1);
        // Source sizes above the store side saturate at the store side.
        lim_r = (src_rows < FRAME_DIM) ? longint'(src_rows) : longint'(FRAME_DIM);
        lim_c = (src_cols < FRAME_DIM) ? longint'(src_cols) : longint'(FRAME_DIM);
        hit = (x >= 0) && (x < lim_r) && (y >= 0) && (y < lim_c);
        xs = int'(x);
        ys = int'(y);
    endfunction

    // Update the predictor for one accepted item.
    task automatic predict_item(input in_item_t it);
        int        xs, ys, addr;
        bit        hit;
        out_item_t due;
        if (it.kind == KIND_LOAD) begin
            load_count++;
            // Loads beyond the store side are dropped.
            if (it.row < FRAME_DIM && it.col < FRAME_DIM) begin
                addr = int'(it.row) * FRAME_DIM + int'(it.col);
                frame_image[addr]  = it.pixel_in;
                frame_loaded[addr] = 1'b1;
            end
        end else begin
            request_count++;
            map_to_source(it.row, it.col, xs, ys, hit);
            due.inside_res = hit;
            due.pixel_out  = hit ? frame_image[xs * FRAME_DIM + ys] : '0;
            expected_pixels.push_back(due);
        end
    endtask

    // Offer one item, idling first at random, and wait for it to be taken.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_item(it);
    endtask

    task automatic send_load(input logic [ROW_W-1:0] row, input logic [ROW_W-1:0] col,
                             input logic [PIX_W-1:0] pixel);
        in_item_t it;
        it.kind     = KIND_LOAD;
        it.row      = row;
        it.col      = col;
        it.pixel_in = pixel;
        send_item(it);
    endtask

    // Send a request, loading its source pixel first if it was never loaded.
    task automatic send_request(input logic [ROW_W-1:0] row, input logic [ROW_W-1:0] col);
        in_item_t it;
        int       xs, ys;
        bit       hit;
        map_to_source(row, col, xs, ys, hit);
        if (hit && !frame_loaded[xs * FRAME_DIM + ys]) begin
            send_load(ROW_W'(xs), ROW_W'(ys), PIX_W'($urandom));
        end
        it.kind     = KIND_REQUEST;
        it.row      = row;
        it.col      = col;
        it.pixel_in = PIX_W'($urandom);
        send_item(it);
    endtask

    // Stop offering items, wait for every result, then let the pipeline empty.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write one register; valid is left high for a following write.
    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        write_count++;
        case (idx)
            REG_SOURCE_ROWS: src_rows = SRC_W'(value);
            REG_SOURCE_COLS: src_cols = SRC_W'(value);
            REG_OUTPUT_SIZE: out_side = OSZ_W'(value);
            REG_COS_ANGLE:   cos_q14  = TRIG_W'(value);
            REG_SIN_ANGLE:   sin_q14  = TRIG_W'(value);
            default: ;
        endcase
    endtask

    // Reprogram all registers once the block is idle.
    task automatic set_config(input int rows, input int cols, input int side,
                              input int cos_v, input int sin_v);
        wait_drained();
        write_reg(REG_SOURCE_ROWS, rows);
        write_reg(REG_SOURCE_COLS, cols);
        write_reg(REG_OUTPUT_SIZE, side);
        write_reg(REG_COS_ANGLE, cos_v);
        write_reg(REG_SIN_ANGLE, sin_v);
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // Source side: mostly small frames, sometimes the extremes.
    function automatic int pick_source_dim();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 1;
        if (r < 18) return FRAME_DIM;
        if (r < 22) return 0;
        if (r < 26) return (1 << SRC_W) - 1;
        return $urandom_range(2, 24);
    endfunction

    function automatic int pick_out_side();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return 0;
        if (r < 16) return (1 << OSZ_W) - 1;
        if (r < 24) return 512;
        if (r < 30) return 1;
        return $urandom_range(2, 48);
    endfunction

    function automatic int pick_trig_extreme();
        case ($urandom_range(5))
            0:       return -32768;
            1:       return 32767;
            2:       return 16384;
            3:       return -16384;
            4:       return 0;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // Mostly a true rotation; sometimes independent extreme codes.
    task automatic pick_angle(output int c, output int s);
        real theta;
        theta = real'($urandom_range(359)) * 3.14159265358979 / 180.0;
        c = int'(16384.0 * $cos(theta));
        s = int'(16384.0 * $sin(theta));
        if ($urandom_range(3) == 0) begin
            c = pick_trig_extreme();
            s = pick_trig_extreme();
        end
    endtask

    // Output coordinate near the center, where requests mostly land inside the frame.
    function automatic logic [ROW_W-1:0] near_center(input int span);
        int v;
        v = int'(out_side >> 1) + int'($urandom_range(2 * span)) - span;
        if (v < 0) v = 0;
        if (v > ROW_MAX) v = ROW_MAX;
        return ROW_W'(v);
    endfunction

    function automatic int center_span();
        int r, c;
        r = (src_rows < FRAME_DIM) ? int'(src_rows) : FRAME_DIM;
        c = (src_cols < FRAME_DIM) ? int'(src_cols) : FRAME_DIM;
        return ((r > c) ? r : c) / 2 + 3;
    endfunction

    // Frame corners with the reset settings, and loads that fall off the store.
    task automatic test_corner_pixels();
        send_load(0, 0, 24'h000000);
        send_load(255, 255, 24'hFFFFFF);
        send_load(0, 255, 24'hA5A5A5);
        send_load(255, 0, 24'h5A5A5A);
        send_load(0, 3, 24'h123456);
        send_load(4, 0, 24'h00FF00);
        // These must be dropped and must not alias onto stored pixels.
        send_load(256, 3, 24'hFEDCBA);
        send_load(3, 256, 24'hFF00FF);
        send_load(ROW_W'(ROW_MAX), ROW_W'(ROW_MAX), 24'hFFFFFF);
        // With the reset settings, output (r, c) maps to source (r-53, c-53).
        send_request(53, 53);
        send_request(308, 308);
        send_request(53, 308);
        send_request(308, 53);
        send_request(53, 56);
        send_request(57, 53);
        send_request(52, 53);
        send_request(309, 53);
        send_request(ROW_W'(ROW_MAX), ROW_W'(ROW_MAX));
        send_request(0, 0);
    endtask

    // Empty source, oversized source, and cosine/sine codes beyond unity.
    task automatic test_special_configs();
        set_config(0, FRAME_DIM, 2, 16384, 0);
        send_request(1, 1);
        send_request(0, 0);
        set_config((1 << SRC_W) - 1, (1 << SRC_W) - 1, 0, 16384, 0);
        send_request(0, 0);
        send_request(1, 0);
        send_request(0, 1);
        set_config(16, 16, 8, -32768, 32767);
        send_request(4, 4);
        send_request(5, 4);
        send_request(4, 5);
        send_request(ROW_W'(ROW_MAX), 0);
    endtask

    // Random phases: new settings and a new idle mix for each.
    task automatic test_random_traffic();
        int idle_mix  [4] = '{0, 73, 0, 36};
        int stall_mix [4] = '{0, 0, 73, 36};
        int rows, cols, c, s, span, r;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            rows = pick_source_dim();
            cols = pick_source_dim();
            pick_angle(c, s);
            set_config(rows, cols, pick_out_side(), c, s);
            src_idle_pct = idle_mix[p % 4];
            dst_stall_pct <= stall_mix[p % 4];
            span = center_span();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                if (r < 65) begin
                    send_request(near_center(span), near_center(span));
                end else if (r < 82) begin
                    send_request(ROW_W'($urandom), ROW_W'($urandom));
                end else begin
                    send_load(ROW_W'($urandom), ROW_W'($urandom), PIX_W'($urandom));
                end
            end
        end
    endtask

    // Hold the output off while items keep coming, so the input stalls.
    task automatic test_output_stall();
        int c, s, span;
        pick_angle(c, s);
        set_config(32, 32, 46, c, s);
        src_idle_pct = 0;
        dst_stall_pct <= 0;
        span = center_span();
        fork
            begin
                output_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                output_hold <= 1'b0;
            end
        join_none
        for (int n = 0; n < 40; n++) begin
            send_request(near_center(span), near_center(span));
        end
    endtask

    // Result side ready, with random stalls and the long hold-off.
    always @(posedge aclk) begin
        m_ready <= !output_hold && ($urandom_range(99) >= dst_stall_pct);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        out_item_t due;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result pixel %06h inside %0b",
                                          m_data.pixel_out, m_data.inside_res));
            end else begin
                due = expected_pixels.pop_front();
                if (m_data.pixel_out !== due.pixel_out) begin
                    report_mismatch($sformatf("result %0d pixel_out %06h, expected %06h",
                                              result_count, m_data.pixel_out,
                                              due.pixel_out));
                end
                if (m_data.inside_res !== due.inside_res) begin
                    report_mismatch($sformatf("result %0d inside_res %0b, expected %0b",
                                              result_count, m_data.inside_res,
                                              due.inside_res));
                end
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_pixels();
        test_special_configs();
        test_random_traffic();
        test_output_stall();
        wait_drained();
        $display("Covered %0d loads and %0d requests; %0d results checked.",
                 load_count, request_count, result_count);
        $display("%0d register writes in %0d settings, four idle mixes, one long hold-off.",
                 write_count, setting_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
